FILE: rtl/core/pcues_pkg.sv
`default_nettype none

package pcues_pkg;

  localparam int CELLS     = 1024;
  localparam int CELL_W    = 10;
  localparam int MAX_EDGES = 32;
  localparam int SLOT_W    = 5;
  localparam int CNT_W     = 6;
  localparam int EDGE_W    = 20;
  localparam int ADDR_W    = CELL_W + SLOT_W;

  typedef enum logic [2:0] {
    ST_ADDED  = 3'd0,
    ST_DUP    = 3'd1,
    ST_FULL   = 3'd2,
    ST_LISTED = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LIST   = 1'b1
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clr_wr;
    logic    load;
    logic    take_count;
    logic    rd_issue;
    logic    consume;
    logic    append;
    logic    out_load;
    status_t out_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic    clr_done;
    action_t act;
    logic    n_zero;
    logic    n_full;
    logic    idx_done;
    logic    pend;
    logic    pend_last;
    logic    hit;
    logic    out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/per_cell_unique_edge_set_builder_unit.sv
`default_nettype none

// Builds a list of distinct edge labels for each of 1024 mesh cells, up to 32 labels a cell.
// An insert word (tuser 0) searches the cell's list and appends the label if absent, giving one
// result word: added, duplicate, or full (label dropped). A list word (tuser 1) returns the
// cell's labels in insertion order, tlast on the final one, or one empty-status word for a cell
// with no labels. After reset the block sweeps its per-cell count memory, one cell per cycle,
// over all 1024 cells with s_tready low. One item is worked at a time and s_tready is high only
// while the block is idle. An insert into a cell holding labels reads the cell's count, decides,
// then reads and compares each stored label in turn from the edge memory before its result word
// is loaded and, if added, the label written; a match ends the search early, and an insert into
// an empty cell goes from the decision straight to the write. A list reads the count, decides,
// then reads the cell's labels and loads one word per cycle while m_tready stays high. s_tready
// returns the cycle after the last result word is loaded. The search pace is set by the single
// read port of the edge memory.
module per_cell_unique_edge_set_builder_unit
  import pcues_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // cell_req [9:0], edge_req [29:10], zero pad [31:30]
  input  wire logic [0:0]  s_tuser,  // action [0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // edge_out [19:0], count [25:20], zero pad [31:26]
  output logic [2:0]       m_tuser,  // status [2:0]
  output logic             m_tlast
);

  cmd_t              cmd;
  sts_t              sts;
  logic [EDGE_W-1:0] out_edge;
  logic [CNT_W-1:0]  out_count;
  status_t           out_status;

  pcues_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcues_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (s_tuser[0]),
    .in_cell    (s_tdata[CELL_W-1:0]),
    .in_edge    (s_tdata[CELL_W+EDGE_W-1:CELL_W]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_edge   (out_edge),
    .out_count  (out_count),
    .out_status (out_status),
    .out_last   (m_tlast)
  );

  assign m_tdata = {6'd0, out_count, out_edge};
  assign m_tuser = out_status;

endmodule

`default_nettype wire

FILE: rtl/core/pcues_ctrl.sv
`default_nettype none

module pcues_ctrl
  import pcues_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_COUNT  = 10'b00_0000_0100,
    S_DECIDE = 10'b00_0000_1000,
    S_SEARCH = 10'b00_0001_0000,
    S_APPEND = 10'b00_0010_0000,
    S_DUP    = 10'b00_0100_0000,
    S_FULL   = 10'b00_1000_0000,
    S_LIST   = 10'b01_0000_0000,
    S_EMPTY  = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.out_status = ST_ADDED;
    in_ready       = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.take_count = 1'b1;
        state_next     = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (sts.act == ACT_LIST && sts.n_zero) begin
          state_next = S_EMPTY;
        end else if (sts.act == ACT_LIST) begin
          state_next = S_LIST;
        end else if (sts.n_zero) begin
          state_next = S_APPEND;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // Reads run one per cycle; each word is compared the cycle after its read.
        cmd.consume  = sts.pend;
        cmd.rd_issue = !sts.idx_done;
        priority if (sts.hit) begin
          state_next = S_DUP;
        end else if (sts.idx_done && !sts.pend) begin
          state_next = sts.n_full ? S_FULL : S_APPEND;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_APPEND: begin
        cmd.out_status = ST_ADDED;
        if (sts.out_free) begin
          cmd.append   = 1'b1;
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DUP: begin
        cmd.out_status = ST_DUP;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FULL: begin
        cmd.out_status = ST_FULL;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_EMPTY: begin
        cmd.out_status = ST_EMPTY;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_LIST: begin
        // A pending read word holds in the memory output until the output register frees.
        cmd.out_status = ST_LISTED;
        cmd.consume    = sts.pend && sts.out_free;
        cmd.out_load   = sts.pend && sts.out_free;
        cmd.rd_issue   = !sts.idx_done && (!sts.pend || sts.out_free);
        if (sts.pend && sts.out_free && sts.pend_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/pcues_dp.sv
`default_nettype none

module pcues_dp
  import pcues_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic              in_action,
  input  wire logic [CELL_W-1:0] in_cell,
  input  wire logic [EDGE_W-1:0] in_edge,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [EDGE_W-1:0]      out_edge,
  output logic [CNT_W-1:0]       out_count,
  output status_t                out_status,
  output logic                   out_last
);

  logic [EDGE_W-1:0] edge_mem [0:(1 << ADDR_W)-1];
  logic [CNT_W-1:0]  count_mem [0:CELLS-1];

  logic [CELL_W-1:0] clr_addr;
  action_t           act;
  logic [CELL_W-1:0] cur_cell;
  logic [EDGE_W-1:0] edge_val;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  n_inc;
  logic              pend;
  logic              pend_last;
  logic [EDGE_W-1:0] edge_rdata;
  logic [CNT_W-1:0]  cnt_rdata;
  logic              out_free;

  assign idx_inc  = idx + 1'b1;
  assign n_inc    = n + 1'b1;
  assign out_free = !out_valid || out_ready;

  // Count memory: cleared by a sweep after reset, one cell per cycle.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      count_mem[clr_addr] <= '0;
    end else if (cmd.append) begin
      count_mem[cur_cell] <= n_inc;
    end
    if (cmd.load) begin
      cnt_rdata <= count_mem[in_cell];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      edge_mem[{cur_cell, n[SLOT_W-1:0]}] <= edge_val;
    end
    if (cmd.rd_issue) begin
      edge_rdata <= edge_mem[{cur_cell, idx[SLOT_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act      <= action_t'(in_action);
      cur_cell <= in_cell;
      edge_val <= in_edge;
    end
    if (cmd.take_count) begin
      n   <= cnt_rdata;
      idx <= '0;
    end else if (cmd.rd_issue) begin
      idx <= idx_inc;
    end
    if (cmd.rd_issue) begin
      pend_last <= (idx_inc == n);
    end
  end

  // A search that stops on a match can leave a read word behind; it is dropped per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.rd_issue) begin
      pend <= 1'b1;
    end else if (cmd.take_count || cmd.consume) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      unique case (cmd.out_status)
        ST_ADDED: begin
          out_edge  <= edge_val;
          out_count <= n_inc;
          out_last  <= 1'b1;
        end
        ST_LISTED: begin
          out_edge  <= edge_rdata;
          out_count <= n;
          out_last  <= pend_last;
        end
        ST_EMPTY: begin
          out_edge  <= '0;
          out_count <= '0;
          out_last  <= 1'b1;
        end
        default: begin
          out_edge  <= edge_val;
          out_count <= n;
          out_last  <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    sts.clr_done  = (clr_addr == CELL_W'(CELLS - 1));
    sts.act       = act;
    sts.n_zero    = (n == '0);
    sts.n_full    = (n == CNT_W'(MAX_EDGES));
    sts.idx_done  = (idx == n);
    sts.pend      = pend;
    sts.pend_last = pend_last;
    sts.hit       = pend && (edge_rdata == edge_val);
    sts.out_free  = out_free;
  end

endmodule

`default_nettype wire
